### src/djb_pkg.sv
`timescale 1ns / 1ps

package djb_pkg;

	// default accumulator width
	localparam int HASH_BITS_DEF = 64;

	// djb2 seed and multiply-by-33 shift
	localparam int unsigned DJB_SEED  = 5381;
	localparam int unsigned DJB_SHIFT = 5;

	// bucket count after reset
	localparam logic [31:0] BUCKET_RESET = 32'd1024;

	// depth of the hash queue between front and back, a power of two
	localparam int QUEUE_DEPTH = 4;

	// back end sequencer states
	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_FIN
	} back_state_t;

	// queue control driven by the front end
	typedef struct packed {
		logic push;
		logic full;
	} queue_ctl_t;

endpackage

### src/djb_ifs.sv
`timescale 1ns / 1ps

// key byte channel
interface djb_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] key_byte;

	modport source (output valid, output key_byte, input ready);
	modport sink (input valid, input key_byte, output ready);
endinterface

// result channel
interface djb_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] bucket_index;
	logic [63:0] hash_value;

	modport source (output valid, output bucket_index, output hash_value, input ready);
	modport sink (input valid, input bucket_index, input hash_value, output ready);
endinterface

// bucket count write channel
interface djb_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] bucket_count;

	modport source (output valid, output bucket_count, input ready);
	modport sink (input valid, input bucket_count, output ready);
endinterface

### src/djb_front.sv
`timescale 1ns / 1ps

module djb_front #(
	parameter int HASH_BITS = djb_pkg::HASH_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	djb_byte_if.sink              key_in,
	input  logic                  q_full,
	output djb_pkg::queue_ctl_t   q_ctl,
	output logic [HASH_BITS-1:0]  q_data
);

	localparam logic [HASH_BITS-1:0] SEED = HASH_BITS'(djb_pkg::DJB_SEED);

	logic [HASH_BITS-1:0] hash_q;
	logic                 accept;
	logic                 term;

	// take a byte whenever the queue can hold a finished key
	assign key_in.ready = !q_full;
	assign accept       = key_in.valid && key_in.ready;
	assign term         = (key_in.key_byte == 8'd0);

	// finished hash goes to the queue on the terminating byte
	assign q_ctl.push = accept && term;
	assign q_ctl.full = q_full;
	assign q_data     = hash_q;

	// accumulator: hash * 33 + byte, back to the seed after each key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= SEED;
		end else if (accept) begin
			if (term) begin
				hash_q <= SEED;
			end else begin
				hash_q <= (hash_q << djb_pkg::DJB_SHIFT) + hash_q
					+ HASH_BITS'(key_in.key_byte);
			end
		end
	end

endmodule

### src/djb_queue.sv
`timescale 1ns / 1ps

module djb_queue #(
	parameter int HASH_BITS = djb_pkg::HASH_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  djb_pkg::queue_ctl_t   q_ctl,
	input  logic [HASH_BITS-1:0]  wr_data,
	output logic                  full,
	output logic                  rd_valid,
	input  logic                  pop,
	output logic [HASH_BITS-1:0]  rd_data
);

	localparam int DEPTH = djb_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	logic [HASH_BITS-1:0] mem_q [DEPTH];
	logic [PW-1:0]        wr_ptr_q;
	logic [PW-1:0]        rd_ptr_q;
	logic [CW-1:0]        cnt_q;
	logic                 do_push;
	logic                 do_pop;

	assign full     = (cnt_q == CW'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_push  = q_ctl.push && !q_ctl.full;
	assign do_pop   = pop && rd_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

### src/djb_back.sv
`timescale 1ns / 1ps

module djb_back #(
	parameter int HASH_BITS = djb_pkg::HASH_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	djb_cfg_if.sink               cfg,
	input  logic                  q_valid,
	input  logic [HASH_BITS-1:0]  q_data,
	output logic                  q_pop,
	djb_result_if.source          result_out
);

	localparam int CW = $clog2(HASH_BITS + 1);

	djb_pkg::back_state_t state_q;
	djb_pkg::back_state_t state_d;

	logic [31:0]          bucket_count_q;
	logic [31:0]          div_q;
	logic [HASH_BITS-1:0] dvd_q;
	logic [HASH_BITS-1:0] hash_q;
	logic [31:0]          rem_q;
	logic [CW-1:0]        cnt_q;
	logic                 out_valid_q;
	logic [31:0]          out_bucket_q;
	logic [63:0]          out_hash_q;

	logic                 out_free;
	logic                 step;
	logic                 load_out;
	logic [32:0]          trial;
	logic [32:0]          diff;
	logic [31:0]          rem_next;

	// configuration register, always writable
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= djb_pkg::BUCKET_RESET;
		end else if (cfg.valid) begin
			bucket_count_q <= cfg.bucket_count;
		end
	end

	// restoring divide step, one quotient bit per cycle
	// a zero divisor always subtracts nothing, leaving the low 32 hash bits
	assign trial    = {rem_q, dvd_q[HASH_BITS-1]};
	assign diff     = trial - {1'b0, div_q};
	assign rem_next = (trial >= {1'b0, div_q}) ? diff[31:0] : trial[31:0];

	assign out_free = !out_valid_q || result_out.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			djb_pkg::B_IDLE: begin
				if (q_valid) begin
					state_d = djb_pkg::B_DIV;
				end
			end
			djb_pkg::B_DIV: begin
				if (cnt_q == CW'(1)) begin
					state_d = djb_pkg::B_FIN;
				end
			end
			djb_pkg::B_FIN: begin
				if (out_free) begin
					state_d = djb_pkg::B_IDLE;
				end
			end
			default: state_d = djb_pkg::B_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		q_pop    = 1'b0;
		step     = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			djb_pkg::B_IDLE: q_pop    = q_valid;
			djb_pkg::B_DIV:  step     = 1'b1;
			djb_pkg::B_FIN:  load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= djb_pkg::B_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				cnt_q <= CW'(HASH_BITS);
			end else if (step) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (q_pop) begin
			dvd_q  <= q_data;
			hash_q <= q_data;
			div_q  <= bucket_count_q;
			rem_q  <= '0;
		end else if (step) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_next;
		end
	end

	// output register parts the divider from the receiver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_bucket_q <= rem_q + 32'd1;
			out_hash_q   <= 64'(hash_q);
		end
	end

	assign result_out.valid        = out_valid_q;
	assign result_out.bucket_index = out_bucket_q;
	assign result_out.hash_value   = out_hash_q;

endmodule

### src/djb2_hash_bucket_select_unit.sv
`timescale 1ns / 1ps

// djb2 string hash with one-based bucket selection
// key_in carries key bytes; a zero byte ends the key and is not hashed.
// each nonzero byte updates hash = hash * 33 + byte, wrapping at HASH_BITS.
// result_out carries one request per key: the hash and (hash mod count) + 1.
// cfg writes the bucket count; write it only while the block is idle.
// a bucket count of zero gives the low 32 hash bits plus one.
// key bytes are taken one per cycle while the hash queue has room.
// the zero byte's hash is queued, then divided and loaded into the output register.
// the back end works on one key at a time on the bit-serial divider;
// the queue holds QUEUE_DEPTH finished hashes, so short keys back up there
// and key_in.ready drops while the queue is full.
// a result waits in the output register while result_out.ready is low; the
// divider keeps working on the next key until it needs that register.
// reset sets the hash to 5381, the bucket count to 1024 and empties the queue.
module djb2_hash_bucket_select_unit #(
	parameter int HASH_BITS = djb_pkg::HASH_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	djb_byte_if.sink      key_in,
	djb_result_if.source  result_out,
	djb_cfg_if.sink       cfg
);

	djb_pkg::queue_ctl_t  q_ctl;
	logic [HASH_BITS-1:0] q_wr_data;
	logic [HASH_BITS-1:0] q_rd_data;
	logic                 q_full;
	logic                 q_valid;
	logic                 q_pop;

	// byte intake and hash accumulator
	djb_front #(.HASH_BITS(HASH_BITS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.key_in (key_in),
		.q_full (q_full),
		.q_ctl  (q_ctl),
		.q_data (q_wr_data)
	);

	// finished hashes waiting for the divider
	djb_queue #(.HASH_BITS(HASH_BITS)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_ctl    (q_ctl),
		.wr_data  (q_wr_data),
		.full     (q_full),
		.rd_valid (q_valid),
		.pop      (q_pop),
		.rd_data  (q_rd_data)
	);

	// bucket selection and result delivery
	djb_back #(.HASH_BITS(HASH_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.q_valid    (q_valid),
		.q_data     (q_rd_data),
		.q_pop      (q_pop),
		.result_out (result_out)
	);

endmodule

### verif/tb_djb2_hash_bucket_select_unit.sv
`timescale 1ns / 1ps

module tb_djb2_hash_bucket_select_unit;

	localparam int HASH_BITS      = djb_pkg::HASH_BITS_DEF;
	localparam int SETTLE_CYCLES  = HASH_BITS + 8;
	localparam int HOLDOFF_CYCLES = 600;
	localparam int STALL_LIMIT    = 3000;
	localparam int PHASE_ITEMS    = 80;

	typedef struct packed {
		logic [31:0] bucket_index;
		logic [63:0] hash_value;
	} bucket_result_t;

	logic clk;
	logic arst_n;

	djb_byte_if   key_in ();
	djb_result_if result_out ();
	djb_cfg_if    cfg ();

	djb2_hash_bucket_select_unit #(
		.HASH_BITS(HASH_BITS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_in    (key_in.sink),
		.result_out(result_out.source),
		.cfg       (cfg.sink)
	);

	// shadow of the block state
	logic [63:0]    model_hash;
	logic [31:0]    model_count;
	bucket_result_t pending_results[$];

	int errors;
	int idle_cycles;
	int holdoff_requests;
	int holdoff_served;
	int holdoff_left;
	int burst_left;
	bit steady_stretch;
	int rx_mode;
	int rx_phase;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] hash_mask();
		if (HASH_BITS >= 64)
			return '1;
		return (64'd1 << HASH_BITS) - 64'd1;
	endfunction

	// one djb2 step: hash * 33 + byte
	function automatic logic [63:0] djb_fold(logic [63:0] h, logic [7:0] kb);
		return ((h << djb_pkg::DJB_SHIFT) + h + {56'd0, kb}) & hash_mask();
	endfunction

	// one-based bucket; a zero count passes the hash through as remainder
	function automatic logic [31:0] bucket_of(logic [63:0] h, logic [31:0] count);
		logic [63:0] rem;
		if (count == 32'd0)
			rem = h;
		else
			rem = h % {32'd0, count};
		return rem[31:0] + 32'd1;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// offer one key byte, honoring burst and gap pattern
	task automatic send_key_byte(logic [7:0] kb);
		int gap;
		if (burst_left == 0) begin
			gap = steady_stretch ? 0 : $urandom_range(6, 1);
			burst_left = $urandom_range(16, 1);
			if (gap > 0) begin
				@(negedge clk);
				key_in.valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		key_in.valid    = 1'b1;
		key_in.key_byte = kb;
		do @(posedge clk); while (!key_in.ready);
		// update the shadow hash on the accepted request
		if (kb != 8'd0) begin
			model_hash = djb_fold(model_hash, kb);
		end else begin
			pending_results.push_back('{bucket_index: bucket_of(model_hash, model_count),
				hash_value: model_hash});
			model_hash = 64'(djb_pkg::DJB_SEED) & hash_mask();
		end
	endtask

	function automatic logic [7:0] random_key_byte();
		int pick;
		pick = $urandom_range(9, 0);
		case (pick)
			0: return 8'hFF;
			1: return 8'h01;
			2: return 8'h80;
			default: return 8'($urandom_range(255, 1));
		endcase
	endfunction

	// random key of mixed length, terminated by a zero byte
	task automatic send_random_key(output int sent);
		int len;
		int pick;
		pick = $urandom_range(99, 0);
		if (pick < 65)
			len = $urandom_range(6, 0);
		else if (pick < 95)
			len = $urandom_range(20, 7);
		else
			len = $urandom_range(48, 21);
		for (int i = 0; i < len; i++)
			send_key_byte(random_key_byte());
		send_key_byte(8'd0);
		sent = len + 1;
	endtask

	// drop valid, wait for all results, then let the back end go quiet
	task automatic settle_idle();
		@(negedge clk);
		key_in.valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_bucket_count(logic [31:0] count);
		settle_idle();
		@(negedge clk);
		cfg.valid        = 1'b1;
		cfg.bucket_count = count;
		do @(posedge clk); while (!cfg.ready);
		model_count = count;
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	task automatic test_empty_key();
		send_key_byte(8'd0);
	endtask

	task automatic test_high_bytes();
		send_key_byte(8'hFF);
		send_key_byte(8'h80);
		send_key_byte(8'h7F);
		send_key_byte(8'h01);
		send_key_byte(8'd0);
	endtask

	// long key forces the accumulator to wrap
	task automatic test_long_key();
		for (int i = 0; i < 18; i++)
			send_key_byte(8'hFF);
		send_key_byte(8'd0);
	endtask

	task automatic test_bucket_extremes();
		write_bucket_count(32'd1);
		send_key_byte(8'h41);
		send_key_byte(8'd0);
		// zero count: low hash bits plus one
		write_bucket_count(32'd0);
		send_key_byte(8'd0);
		for (int i = 0; i < 12; i++)
			send_key_byte(8'hFF);
		send_key_byte(8'd0);
		write_bucket_count(32'hFFFF_FFFF);
		send_key_byte(8'hFE);
		send_key_byte(8'd0);
	endtask

	// receiver holds off while the sender streams short keys
	task automatic test_backpressure();
		write_bucket_count(32'd13);
		steady_stretch = 1'b1;
		holdoff_requests++;
		for (int i = 0; i < 16; i++) begin
			if ($urandom_range(1, 0))
				send_key_byte(random_key_byte());
			send_key_byte(8'd0);
		end
		steady_stretch = 1'b0;
	endtask

	task automatic test_random_mix();
		logic [31:0] settings[7];
		int sent;
		int count;
		settings[0] = djb_pkg::BUCKET_RESET;
		settings[1] = 32'd1;
		settings[2] = 32'd0;
		settings[3] = 32'hFFFF_FFFF;
		settings[4] = 32'd7;
		settings[5] = 32'($urandom_range(100, 2));
		settings[6] = $urandom() | 32'h8000_0000;
		foreach (settings[s]) begin
			write_bucket_count(settings[s]);
			count = 0;
			while (count < PHASE_ITEMS) begin
				if ($urandom_range(5, 0) == 0)
					steady_stretch = ~steady_stretch;
				send_random_key(sent);
				count += sent;
			end
			steady_stretch = 1'b0;
		end
	endtask

	// main sequence
	initial begin
		arst_n           = 1'b0;
		key_in.valid     = 1'b0;
		key_in.key_byte  = 8'd0;
		cfg.valid        = 1'b0;
		cfg.bucket_count = 32'd0;
		model_hash       = 64'(djb_pkg::DJB_SEED) & hash_mask();
		model_count      = djb_pkg::BUCKET_RESET;
		errors           = 0;
		holdoff_requests = 0;
		burst_left       = 0;
		steady_stretch   = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_key();
		test_high_bytes();
		test_long_key();
		test_bucket_extremes();
		test_backpressure();
		test_random_mix();

		settle_idle();
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// receiver ready pattern with an occasional long hold-off
	initial begin
		result_out.ready = 1'b0;
		holdoff_served   = 0;
		holdoff_left     = 0;
		rx_mode          = 0;
		rx_phase         = 0;
		forever begin
			@(negedge clk);
			if (holdoff_served != holdoff_requests) begin
				holdoff_served = holdoff_requests;
				holdoff_left   = HOLDOFF_CYCLES;
			end
			rx_phase++;
			if (rx_phase % 100 == 0)
				rx_mode = $urandom_range(3, 0);
			if (holdoff_left > 0) begin
				holdoff_left--;
				result_out.ready = 1'b0;
			end else begin
				case (rx_mode)
					0: result_out.ready = 1'b1;
					1: result_out.ready = ($urandom_range(3, 0) != 0);
					2: result_out.ready = ((rx_phase % 24) < 14);
					default: result_out.ready = $urandom_range(1, 0);
				endcase
			end
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin : result_check
		bucket_result_t want;
		if (arst_n && result_out.valid && result_out.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", result_out.hash_value, 64'd0);
			end else begin
				want = pending_results.pop_front();
				if (result_out.hash_value !== want.hash_value)
					report_mismatch("hash_value", result_out.hash_value, want.hash_value);
				if (result_out.bucket_index !== want.bucket_index)
					report_mismatch("bucket_index", 64'(result_out.bucket_index),
						64'(want.bucket_index));
			end
		end
	end

	// watchdog on cycles with no accepted request
	always @(posedge clk) begin : stall_watch
		if (!arst_n || (key_in.valid && key_in.ready) || (cfg.valid && cfg.ready) ||
			(result_out.valid && result_out.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

endmodule

### sim.f
src/djb_pkg.sv
src/djb_ifs.sv
src/djb_front.sv
src/djb_queue.sv
src/djb_back.sv
src/djb2_hash_bucket_select_unit.sv
verif/tb_djb2_hash_bucket_select_unit.sv
